// File: hdl/nfrt_pkg.sv
package nfrt_pkg;

	localparam int FLOOR_W = 6;
	localparam int TALLY_W = 7;
	localparam int MAX_MAP = 64;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_CANCEL  = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;
	localparam logic [1:0] OP_NEXT    = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [FLOOR_W-1:0] floor;
	} req_beat_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] chosen_floor;
		logic               is_pending;
		logic [TALLY_W-1:0] pending_total;
		logic               status;
	} rsp_beat_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hdl/nfrt_ctrl.sv
module nfrt_ctrl import nfrt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_op,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd,
	output logic       req_stall
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_op == OP_NEXT) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the result register can take the beat
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/nfrt_dp.sv
module nfrt_dp import nfrt_pkg::*; #(
	parameter int NUM_FLOORS = 64,
	parameter int MAP_N      = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t req,
	input  ctrl_cmd_t cmd,
	input  logic      rsp_stall,
	output dp_stat_t  stat,
	output logic      rsp_valid,
	output rsp_beat_t rsp
);

	localparam int         IDX_W     = (MAP_N > 1) ? $clog2(MAP_N) : 1;
	localparam logic [8:0] FLOOR_LIM = 9'(NUM_FLOORS);

	logic [MAP_N-1:0]   map_q, map_d;
	logic [TALLY_W-1:0] tally_q, tally_d;
	logic [1:0]         op_q;
	logic [FLOOR_W-1:0] floor_q;
	logic [IDX_W-1:0]   cnt_q, best_q;
	logic [FLOOR_W-1:0] best_d_q;
	logic               found_q;
	rsp_beat_t          rsp_q, res;
	logic               rsp_valid_q;

	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic               cur_bit;
	logic [FLOOR_W-1:0] cnt_f, gap;
	logic               take;

	assign in_range = 9'(floor_q) < FLOOR_LIM;
	assign idx      = floor_q[IDX_W-1:0];
	assign cur_bit  = in_range && map_q[idx];

	// scan step: one floor per cycle, strict compare keeps the lower floor on ties
	assign cnt_f = FLOOR_W'(cnt_q);
	assign gap   = (floor_q > cnt_f) ? (floor_q - cnt_f) : (cnt_f - floor_q);
	assign take  = map_q[cnt_q] && (!found_q || (gap < best_d_q));

	always_comb begin
		map_d   = map_q;
		tally_d = tally_q;
		res     = '0;
		case (op_q)
			OP_REQUEST: begin
				if (!in_range) begin
					res.status = 1'b1;
				end else if (!map_q[idx]) begin
					map_d[idx] = 1'b1;
					tally_d    = tally_q + TALLY_W'(1);
				end
			end
			OP_CANCEL: begin
				if (cur_bit) begin
					map_d[idx] = 1'b0;
					tally_d    = tally_q - TALLY_W'(1);
				end else begin
					res.status = 1'b1;
				end
			end
			OP_QUERY: begin
				res.is_pending = cur_bit;
			end
			default: begin
				if (found_q) begin
					map_d[best_q]    = 1'b0;
					tally_d          = tally_q - TALLY_W'(1);
					res.chosen_floor = FLOOR_W'(best_q);
				end else begin
					res.status = 1'b1;
				end
			end
		endcase
		res.pending_total = tally_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			tally_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				map_q       <= map_d;
				tally_q     <= tally_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req.opcode;
			floor_q <= req.floor;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (take) begin
				found_q  <= 1'b1;
				best_q   <= cnt_q;
				best_d_q <= gap;
			end
		end
		if (cmd.finish) begin
			rsp_q <= res;
		end
	end

	assign stat.scan_last = (cnt_q == IDX_W'(MAP_N - 1));
	assign stat.out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;

endmodule

// File: hdl/nearest_floor_request_table.sv
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  req_beat_t  {opcode, floor}
// rsp       out  rsp_valid/rsp_stall  rsp_beat_t  {chosen_floor, is_pending, pending_total, status}
//
// Request, cancel and query: accept in idle, then update and result load in finish.
// Next: accept, then a scan as the datapath walks the pending map one floor per
// cycle, then finish. req_stall stays high from accept until finish completes.
// Reset clears the map and the count; the block takes a beat right after.
// A result waiting under rsp_stall does not block the next accept; the
// following result waits in the finish state until the register drains.
module nearest_floor_request_table import nfrt_pkg::*; #(
	parameter int NUM_FLOORS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	// floors above 63 cannot be addressed, so the map stops there
	localparam int MAP_N = (NUM_FLOORS < MAX_MAP) ? NUM_FLOORS : MAX_MAP;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: idle / scan / finish
	nfrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.opcode),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	// pending map, count, nearest-floor scan and result register
	nfrt_dp #(
		.NUM_FLOORS (NUM_FLOORS),
		.MAP_N      (MAP_N)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// a finish never overwrites a beat still waiting downstream
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.out_free)
		else $error("result register overwritten");

	// a finish always presents a beat next cycle
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid)
		else $error("finished item produced no beat");

	// after an accept the block is busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("accepted beat while busy");

	// the count never exceeds the number of addressable floors
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.pending_total <= TALLY_W'(MAP_N)))
		else $error("pending count out of range");

endmodule
